// ----- src/tpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Throttle plausibility window monitor package
// Shared constants, register codes, the sequencer state type and the
// structs that travel between the configuration, divider and core modules.
// ----------------------------------------------------------------------------
package tpwm_pkg;

  // Window store geometry.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths.
  localparam int unsigned LVL_W   = 14;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned FRAC_W  = 9;
  localparam int unsigned TOT_W   = 22;
  localparam int unsigned SCALE_W = 8;

  // Error scale: hundredths of a percent.
  localparam logic [LVL_W-1:0] PCT_SCALE = LVL_W'(10000);
  localparam logic [ERR_W-1:0] ERR_MAX   = '1;

  // Shared divider geometry.
  localparam int unsigned DVD_W     = 2 * LVL_W;
  localparam int unsigned DSR_W     = LVL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  // Configuration port.
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_WINDOW_TICKS   = 3'd0,
    REG_TP_ERROR_LIMIT = 3'd1,
    REG_BRAKE_FRAC_LIM = 3'd2,
    REG_BRAKE_APPLY    = 3'd3,
    REG_THROTTLE_OPEN  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] window_ticks;
    logic [ERR_W-1:0]  tp_error_limit;
    logic [FRAC_W-1:0] brake_fraction_limit;
    logic [LVL_W-1:0]  brake_apply_level;
    logic [LVL_W-1:0]  throttle_open_level;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_EGO,
    S_EWAIT,
    S_FULL,
    S_INS,
    S_AWAIT,
    S_AGE,
    S_MGO,
    S_MWAIT,
    S_FGO,
    S_FWAIT,
    S_OUT
  } state_t;

endpackage

// ----- src/tpwm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style register bank holding the window length, the fault limits and
// the brake and throttle levels.
// ----------------------------------------------------------------------------
module tpwm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tpwm_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [tpwm_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [tpwm_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output tpwm_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg.window_ticks         <= 32'd1000;
      cfg.tp_error_limit       <= 16'd1000;
      cfg.brake_fraction_limit <= 9'd128;
      cfg.brake_apply_level    <= 14'd500;
      cfg.throttle_open_level  <= 14'd1000;
    end else if (wr_en) begin
      case (idx)
        tpwm_pkg::REG_WINDOW_TICKS:   cfg.window_ticks         <= cfg_pwdata;
        tpwm_pkg::REG_TP_ERROR_LIMIT: cfg.tp_error_limit       <= cfg_pwdata[15:0];
        tpwm_pkg::REG_BRAKE_FRAC_LIM: cfg.brake_fraction_limit <= cfg_pwdata[8:0];
        tpwm_pkg::REG_BRAKE_APPLY:    cfg.brake_apply_level    <= cfg_pwdata[13:0];
        tpwm_pkg::REG_THROTTLE_OPEN:  cfg.throttle_open_level  <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      tpwm_pkg::REG_WINDOW_TICKS:   cfg_prdata = cfg.window_ticks;
      tpwm_pkg::REG_TP_ERROR_LIMIT: cfg_prdata = {16'd0, cfg.tp_error_limit};
      tpwm_pkg::REG_BRAKE_FRAC_LIM: cfg_prdata = {23'd0, cfg.brake_fraction_limit};
      tpwm_pkg::REG_BRAKE_APPLY:    cfg_prdata = {18'd0, cfg.brake_apply_level};
      tpwm_pkg::REG_THROTTLE_OPEN:  cfg_prdata = {18'd0, cfg.throttle_open_level};
      default:                      cfg_prdata = '0;
    endcase
  end

endmodule

// ----- src/tpwm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared iterative divider
// Restoring unsigned divider, one quotient bit per cycle. Used in turn for
// the sample error, the window mean and the brake fraction.
// ----------------------------------------------------------------------------
module tpwm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpwm_pkg::div_req_t          req,
  output logic                        done,
  output logic [tpwm_pkg::DVD_W-1:0]  quot
);

  logic                            busy_r;
  logic                            done_r;
  logic [tpwm_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [tpwm_pkg::DVD_W-1:0]      dvd_r;
  logic [tpwm_pkg::DSR_W-1:0]      rem_r;
  logic [tpwm_pkg::DSR_W-1:0]      dsr_r;
  logic [tpwm_pkg::DSR_W:0]        rem_sh;
  logic [tpwm_pkg::DSR_W:0]        rem_sub;
  logic                            ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_r, dvd_r[tpwm_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= tpwm_pkg::DIV_CNT_W'(tpwm_pkg::DVD_W - 1);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != '0);
      done_r <= (cnt_r == '0);
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath; the dividend register collects the quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[tpwm_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[tpwm_pkg::DSR_W-1:0] : rem_sh[tpwm_pkg::DSR_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

  // A result is flagged only at the end of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  // A division runs its full step count.
  a_busy_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != '0 && !req.start) |=> busy_r)
    else $error("divider stopped early");

  // A start always leads into a busy divider.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (busy_r && !done_r))
    else $error("divider did not start");

endmodule

// ----- src/tpwm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window sequencer
// Computes the sample error and brake flag, keeps the time-stamped window
// store and its running totals, ages out old entries and forms the result.
// ----------------------------------------------------------------------------
module tpwm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpwm_pkg::cfg_t                cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [79:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,
  output tpwm_pkg::div_req_t            div_req,
  input  logic                          div_done,
  input  logic [tpwm_pkg::DVD_W-1:0]    div_quot
);

  tpwm_pkg::state_t state_r, state_nxt;

  // Latched sample.
  logic [tpwm_pkg::LVL_W-1:0]  act_r;
  logic [tpwm_pkg::LVL_W-1:0]  exp_r;
  logic [tpwm_pkg::TIME_W-1:0] ts_r;
  logic                        flag_r;
  logic [tpwm_pkg::DVD_W-1:0]  prod_r;
  logic [tpwm_pkg::ERR_W-1:0]  err_r;
  logic [tpwm_pkg::ERR_W-1:0]  mean_r;

  // Window bookkeeping.
  logic [tpwm_pkg::TOT_W-1:0]  error_total_r;
  logic [tpwm_pkg::CNT_W-1:0]  brake_total_r;
  logic [tpwm_pkg::CNT_W-1:0]  count_r;
  logic [tpwm_pkg::PTR_W-1:0]  oldest_r;
  logic [tpwm_pkg::PTR_W-1:0]  newest_r;

  // Window store and its registered read of the oldest entry.
  logic [tpwm_pkg::TIME_W-1:0] mem_time [tpwm_pkg::DEPTH];
  logic [tpwm_pkg::ERR_W-1:0]  mem_err  [tpwm_pkg::DEPTH];
  logic                        mem_brk  [tpwm_pkg::DEPTH];
  logic [tpwm_pkg::TIME_W-1:0] rd_time_r;
  logic [tpwm_pkg::ERR_W-1:0]  rd_err_r;
  logic                        rd_brk_r;

  // Output register.
  logic                        out_valid_r;
  logic [39:0]                 out_data_r;

  logic [tpwm_pkg::LVL_W-1:0]  in_act, in_exp, in_brk;
  logic [tpwm_pkg::TIME_W-1:0] in_ts;
  logic [tpwm_pkg::LVL_W-1:0]  diff;
  logic [tpwm_pkg::TIME_W-1:0] age;
  logic                        too_old;
  logic                        full;
  logic                        mem_we;
  logic                        out_free;
  logic                        out_load;
  logic [tpwm_pkg::FRAC_W-1:0] frac;
  logic                        fault;

  assign in_act = in_tdata[13:0];
  assign in_exp = in_tdata[27:14];
  assign in_brk = in_tdata[41:28];
  assign in_ts  = in_tdata[73:42];

  assign diff    = (act_r > exp_r) ? (act_r - exp_r) : (exp_r - act_r);
  assign age     = ts_r - rd_time_r;
  assign too_old = (count_r > tpwm_pkg::CNT_W'(1)) && (age > cfg.window_ticks);
  assign full    = (count_r == tpwm_pkg::CNT_W'(tpwm_pkg::DEPTH));
  assign out_free = !out_valid_r || out_tready;
  assign frac    = div_quot[tpwm_pkg::FRAC_W-1:0];
  assign fault   = (mean_r > cfg.tp_error_limit) || (frac > cfg.brake_fraction_limit);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpwm_pkg::S_IDLE:  if (in_tvalid) state_nxt = tpwm_pkg::S_MUL;
      tpwm_pkg::S_MUL:   state_nxt = (exp_r == '0) ? tpwm_pkg::S_FULL : tpwm_pkg::S_EGO;
      tpwm_pkg::S_EGO:   state_nxt = tpwm_pkg::S_EWAIT;
      tpwm_pkg::S_EWAIT: if (div_done) state_nxt = tpwm_pkg::S_FULL;
      tpwm_pkg::S_FULL:  state_nxt = tpwm_pkg::S_INS;
      tpwm_pkg::S_INS:   state_nxt = tpwm_pkg::S_AWAIT;
      tpwm_pkg::S_AWAIT: state_nxt = tpwm_pkg::S_AGE;
      tpwm_pkg::S_AGE:   state_nxt = too_old ? tpwm_pkg::S_AWAIT : tpwm_pkg::S_MGO;
      tpwm_pkg::S_MGO:   state_nxt = tpwm_pkg::S_MWAIT;
      tpwm_pkg::S_MWAIT: if (div_done) state_nxt = tpwm_pkg::S_FGO;
      tpwm_pkg::S_FGO:   state_nxt = tpwm_pkg::S_FWAIT;
      // A result loaded straight away goes back to idle; otherwise it waits.
      tpwm_pkg::S_FWAIT: if (div_done) state_nxt = out_free ? tpwm_pkg::S_IDLE
                                                            : tpwm_pkg::S_OUT;
      tpwm_pkg::S_OUT:   if (out_free) state_nxt = tpwm_pkg::S_IDLE;
      default:           state_nxt = tpwm_pkg::S_IDLE;
    endcase
  end

  // Control outputs and divider requests.
  always_comb begin
    in_tready        = 1'b0;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = exp_r;
    unique case (state_r)
      tpwm_pkg::S_IDLE: in_tready = 1'b1;
      tpwm_pkg::S_EGO:  div_req.start = 1'b1;
      tpwm_pkg::S_INS:  mem_we = 1'b1;
      tpwm_pkg::S_MGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tpwm_pkg::DVD_W'(error_total_r);
        div_req.divisor  = tpwm_pkg::DSR_W'(count_r);
      end
      tpwm_pkg::S_FGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tpwm_pkg::DVD_W'({brake_total_r, {tpwm_pkg::SCALE_W{1'b0}}});
        div_req.divisor  = tpwm_pkg::DSR_W'(count_r);
      end
      tpwm_pkg::S_FWAIT: out_load = div_done && out_free;
      tpwm_pkg::S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tpwm_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sample capture, error product and error quotient.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= in_act;
      exp_r  <= in_exp;
      ts_r   <= in_ts;
      flag_r <= (in_brk > cfg.brake_apply_level) && (in_act > cfg.throttle_open_level);
    end
    if (state_r == tpwm_pkg::S_MUL) begin
      prod_r <= tpwm_pkg::DVD_W'(diff) * tpwm_pkg::DVD_W'(tpwm_pkg::PCT_SCALE);
      err_r  <= tpwm_pkg::ERR_MAX;
    end
    if (state_r == tpwm_pkg::S_EWAIT && div_done) begin
      err_r <= (div_quot > tpwm_pkg::DVD_W'(tpwm_pkg::ERR_MAX)) ?
               tpwm_pkg::ERR_MAX : div_quot[tpwm_pkg::ERR_W-1:0];
    end
    if (state_r == tpwm_pkg::S_MWAIT && div_done) begin
      mean_r <= div_quot[tpwm_pkg::ERR_W-1:0];
    end
  end

  // Totals, count and pointers: drop the oldest when full, insert, then drop aged-out entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_total_r <= '0;
      brake_total_r <= '0;
      count_r       <= '0;
      oldest_r      <= '0;
      newest_r      <= '0;
    end else if ((state_r == tpwm_pkg::S_FULL && full) ||
                 (state_r == tpwm_pkg::S_AGE && too_old)) begin
      error_total_r <= error_total_r - tpwm_pkg::TOT_W'(rd_err_r);
      brake_total_r <= brake_total_r - tpwm_pkg::CNT_W'(rd_brk_r);
      count_r       <= count_r - 1'b1;
      oldest_r      <= oldest_r + 1'b1;
    end else if (mem_we) begin
      error_total_r <= error_total_r + tpwm_pkg::TOT_W'(err_r);
      brake_total_r <= brake_total_r + tpwm_pkg::CNT_W'(flag_r);
      count_r       <= count_r + 1'b1;
      newest_r      <= newest_r + 1'b1;
    end
  end

  // Window store: one write port at the newest slot, one read at the oldest.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_time[newest_r] <= ts_r;
      mem_err[newest_r]  <= err_r;
      mem_brk[newest_r]  <= flag_r;
    end
    rd_time_r <= mem_time[oldest_r];
    rd_err_r  <= mem_err[oldest_r];
    rd_brk_r  <= mem_brk[oldest_r];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'd0, count_r, flag_r, frac, mean_r, fault};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The newest pointer always sits the entry count past the oldest one.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    newest_r == (oldest_r + count_r[tpwm_pkg::PTR_W-1:0]))
    else $error("window pointers disagree with entry count");

  // Flagged entries never outnumber entries; the window never overflows.
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (brake_total_r <= count_r) && (count_r <= tpwm_pkg::CNT_W'(tpwm_pkg::DEPTH)))
    else $error("window totals out of range");

  // Averages are taken only over a non-empty window.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpwm_pkg::S_MGO || state_r == tpwm_pkg::S_FGO) |-> (count_r != '0))
    else $error("average over an empty window");

  // An accepted transaction starts the error computation.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == tpwm_pkg::S_MUL))
    else $error("accepted sample did not start processing");

endmodule

// ----- src/throttle_plausibility_window_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Throttle plausibility window monitor
// Samples are processed one at a time: a new one is taken only once the last
// result is loaded. The shared 28-step divider, used up to three times per
// sample, sets the pace; each aged-out entry adds another pass of ageing.
// A loaded result waits in an output register while the next sample enters.
// Synchronous active-low reset empties the window and loads register defaults.
// ----------------------------------------------------------------------------
module throttle_plausibility_window_monitor (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input: throttle_actual[13:0], throttle_expected[27:14], brake_level[41:28],
  // timestamp[73:42], zero pad.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [79:0]                  in_tdata,
  // Output: fault[0], mean_tp_error[16:1], brake_fraction[25:17],
  // brake_flag[26], window_count[33:27], zero pad.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tpwm_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [tpwm_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [tpwm_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  tpwm_pkg::cfg_t                  cfg;
  tpwm_pkg::div_req_t              div_req;
  logic                            div_done;
  logic [tpwm_pkg::DVD_W-1:0]      div_quot;

  // Register bank.
  tpwm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Shared divider.
  tpwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer and window store.
  tpwm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_quot   (div_quot)
  );

endmodule
